/* src/cell_mode_vote_byte_decoder_assert.svh */
// ----------------------------------------------------------------------------
// Cell mode vote byte decoder assertion macros
// Shorthand for clocked assertions that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef CELL_MODE_VOTE_BYTE_DECODER_ASSERT_SVH
`define CELL_MODE_VOTE_BYTE_DECODER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge of clk.
`define CMVB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge of clk.
`define CMVB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/cmvb_pkg.sv */
// ----------------------------------------------------------------------------
// Cell mode vote byte decoder package
// Shared constants, state encodings and the mode walk result type.
// ----------------------------------------------------------------------------
package cmvb_pkg;

	localparam int unsigned MAX_CELL_SIDE_DEF = 8;
	localparam logic [3:0] CELL_SIDE_RESET = 4'd4;
	localparam logic [7:0] MODE_THRESHOLD = 8'd100;
	localparam logic [2:0] LAST_BIT_POS = 3'd7;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_WALK,
		ST_PACK
	} top_state_t;

	typedef enum logic [2:0] {
		W_IDLE,
		W_FETCH,
		W_HOLD,
		W_SCAN,
		W_DONE
	} walk_state_t;

	typedef struct packed {
		logic       done;
		logic [7:0] mode;
	} walk_res_t;

endpackage

/* src/cmvb_cell_mem.sv */
// ----------------------------------------------------------------------------
// Cell pixel store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cmvb_cell_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/cmvb_mode_walk.sv */
// ----------------------------------------------------------------------------
// Cell mode walk
// Counts the occurrences of every stored value with one shared comparator
// and keeps the first value that reaches the highest count.
// ----------------------------------------------------------------------------
module cmvb_mode_walk #(
	parameter int unsigned AW = 6,
	parameter int unsigned CW = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [AW-1:0]      last_idx,
	input  logic [7:0]         rd_data,
	output logic [AW-1:0]      rd_addr,
	output cmvb_pkg::walk_res_t res
);

	cmvb_pkg::walk_state_t state_q, state_d;
	logic [AW-1:0] last_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] k_q;
	logic [7:0]    vi_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] best_cnt_q;
	logic [7:0]    best_val_q;
	logic [CW-1:0] cnt_new;

	assign cnt_new = cnt_q + CW'(rd_data == vi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmvb_pkg::W_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_addr = i_q;
		res.done = 1'b0;
		res.mode = best_val_q;
		case (state_q)
			cmvb_pkg::W_IDLE: begin
				if (start) begin
					state_d = cmvb_pkg::W_FETCH;
				end
			end
			cmvb_pkg::W_FETCH: begin
				rd_addr = i_q;
				state_d = cmvb_pkg::W_HOLD;
			end
			cmvb_pkg::W_HOLD: begin
				rd_addr = '0;
				state_d = cmvb_pkg::W_SCAN;
			end
			cmvb_pkg::W_SCAN: begin
				rd_addr = k_q + AW'(1);
				if (k_q == last_q) begin
					if (i_q == last_q) begin
						state_d = cmvb_pkg::W_DONE;
					end else begin
						state_d = cmvb_pkg::W_FETCH;
					end
				end
			end
			cmvb_pkg::W_DONE: begin
				res.done = 1'b1;
				state_d = cmvb_pkg::W_IDLE;
			end
			default: begin
				state_d = cmvb_pkg::W_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cmvb_pkg::W_IDLE: begin
				if (start) begin
					last_q     <= last_idx;
					i_q        <= '0;
					best_cnt_q <= '0;
				end
			end
			cmvb_pkg::W_HOLD: begin
				vi_q  <= rd_data;
				k_q   <= '0;
				cnt_q <= '0;
			end
			cmvb_pkg::W_SCAN: begin
				cnt_q <= cnt_new;
				k_q   <= k_q + AW'(1);
				if (k_q == last_q) begin
					i_q <= i_q + AW'(1);
					if (cnt_new > best_cnt_q) begin
						best_cnt_q <= cnt_new;
						best_val_q <= vi_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* src/cell_mode_vote_byte_decoder.sv */
// ----------------------------------------------------------------------------
// Cell mode vote byte decoder
// Stores one square cell of pixels, takes the mode of the cell, turns it
// into one bit and packs eight such bits into each output byte.
//
//   Channel  Direction  Contents
//   s_*      in         pixel_value, first_of_image
//   m_*      out        data_byte
//   cfg_*    in         cell_side
//
// A pixel that does not end its cell leaves the input open for the next one.
// After the last pixel of a cell is taken, the input stays closed through the
// mode walk, which compares one pair of stored values per cycle, through the
// hand-over of its result and through the packing of its bit.
// Reset leaves cell_side at 4, the pixel count and the bit packer at zero.
// An output byte waits in its register while the next cell is loaded; the
// input stalls only if a new byte is finished before the old one is taken.
// ----------------------------------------------------------------------------
module cell_mode_vote_byte_decoder #(
	parameter int unsigned MAX_CELL_SIDE = cmvb_pkg::MAX_CELL_SIDE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] pixel_value
	input  logic       s_tuser,   // [0] first_of_image
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] data_byte
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata  // [3:0] cell_side
);

	localparam int unsigned DEPTH = MAX_CELL_SIDE * MAX_CELL_SIDE;
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = $clog2(MAX_CELL_SIDE + 1);

	cmvb_pkg::top_state_t state_q, state_d;
	cmvb_pkg::walk_res_t  walk_res;

	logic [3:0]    cell_side_q;
	logic [SW-1:0] side_eff;
	logic [CW-1:0] n_pix;
	logic [CW-1:0] pix_cnt_q;
	logic [CW-1:0] pix_base;
	logic [CW-1:0] pix_next;
	logic [7:0]    packed_q;
	logic [2:0]    bit_pos_q;
	logic          bit_q;
	logic [7:0]    packed_new;
	logic [7:0]    out_q;
	logic          out_valid_q;
	logic          in_fire;
	logic          cell_end;
	logic          slot_free;
	logic          byte_full;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	always_comb begin
		if (cell_side_q == 4'd0) begin
			side_eff = SW'(1);
		end else if (32'(cell_side_q) > 32'(MAX_CELL_SIDE)) begin
			side_eff = SW'(MAX_CELL_SIDE);
		end else begin
			side_eff = SW'(cell_side_q);
		end
	end

	assign n_pix      = CW'(side_eff) * CW'(side_eff);
	assign in_fire    = s_tvalid && s_tready;
	assign pix_base   = (s_tuser || pix_cnt_q >= n_pix) ? '0 : pix_cnt_q;
	assign pix_next   = pix_base + CW'(1);
	assign cell_end   = pix_next >= n_pix;
	assign slot_free  = !out_valid_q || m_tready;
	assign byte_full  = bit_pos_q == cmvb_pkg::LAST_BIT_POS;
	assign packed_new = packed_q | (8'(bit_q) << bit_pos_q);
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_q;

	cmvb_cell_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (in_fire),
		.waddr (pix_base[AW-1:0]),
		.wdata (s_tdata),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	cmvb_mode_walk #(
		.AW (AW),
		.CW (CW)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_fire && cell_end),
		.last_idx (AW'(n_pix - CW'(1))),
		.rd_data  (rd_data),
		.rd_addr  (rd_addr),
		.res      (walk_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmvb_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			cmvb_pkg::ST_LOAD: begin
				s_tready = 1'b1;
				if (in_fire && cell_end) begin
					state_d = cmvb_pkg::ST_WALK;
				end
			end
			cmvb_pkg::ST_WALK: begin
				if (walk_res.done) begin
					state_d = cmvb_pkg::ST_PACK;
				end
			end
			cmvb_pkg::ST_PACK: begin
				if (!byte_full || slot_free) begin
					state_d = cmvb_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = cmvb_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_side_q <= cmvb_pkg::CELL_SIDE_RESET;
			pix_cnt_q   <= '0;
			packed_q    <= '0;
			bit_pos_q   <= '0;
			bit_q       <= 1'b0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == cmvb_pkg::ST_PACK && byte_full && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				cell_side_q <= cfg_wdata;
				pix_cnt_q   <= '0;
			end else if (in_fire) begin
				pix_cnt_q <= cell_end ? '0 : pix_next;
			end
			case (state_q)
				cmvb_pkg::ST_LOAD: begin
					if (in_fire && s_tuser) begin
						packed_q  <= '0;
						bit_pos_q <= '0;
					end
				end
				cmvb_pkg::ST_WALK: begin
					if (walk_res.done) begin
						bit_q <= walk_res.mode > cmvb_pkg::MODE_THRESHOLD;
					end
				end
				cmvb_pkg::ST_PACK: begin
					if (!byte_full) begin
						packed_q  <= packed_new;
						bit_pos_q <= bit_pos_q + 3'd1;
					end else if (slot_free) begin
						out_q     <= packed_new;
						packed_q  <= '0;
						bit_pos_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* src/cmvb_checker.sv */
// ----------------------------------------------------------------------------
// Cell mode vote byte decoder port checker
// Watches the top level ports and is attached to every instance by a bind.
// ----------------------------------------------------------------------------
`include "cell_mode_vote_byte_decoder_assert.svh"

module cmvb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// A byte that is not taken stays offered and unchanged.
	`CMVB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output transaction dropped or changed while stalled")

	// A byte comes only after a full mode walk, never right after a pixel.
	`CMVB_ASSERT_NXT(a_no_fast_out, s_tvalid && s_tready, !$rose(m_tvalid), "output byte appeared directly after an input transaction")

	// A new byte is offered as the block finishes packing and reopens the input.
	`CMVB_ASSERT_NOW(a_out_reopens, $rose(m_tvalid), s_tready && !$past(s_tready), "new output byte not aligned with the end of a mode walk")

endmodule

bind cell_mode_vote_byte_decoder cmvb_checker u_checker (.*);
